FILE: sv/crdg_pkg.sv
// ----------------------------------------------------------------------------
// crdg_pkg: shared definitions for the camera ray direction generator
// Widths, register indexes, pipeline bundles and the reciprocal square root
// seed table.
// ----------------------------------------------------------------------------
package crdg_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int SEED_BITS    = 6;
  localparam int NEWTON_STEPS = 3;

  localparam int PIX_W    = 12;
  localparam int COMP_W   = 32;
  localparam int STEP_W   = COMP_W + PIX_W + 1;
  localparam int V_W      = 46;
  localparam int MAG_W    = 45;
  localparam int MAG_LO_W = 23;
  localparam int MAG_HI_W = MAG_W - MAG_LO_W;
  localparam int LEN_W    = 92;
  localparam int CHUNK_W  = 16;
  localparam int CHUNKS   = 6;
  localparam int CIDX_W   = 3;
  localparam int POS_W    = 4;
  localparam int K_W      = 6;
  localparam int M_W      = 32;
  localparam int Y_W      = 32;
  localparam int T_W      = 34;
  localparam int U_W      = 33;
  localparam int H_W      = 31;
  localparam int FRAC     = 30;
  localparam int OUT_W    = 32;
  localparam int PROD_W   = MAG_W + Y_W;

  localparam int SEED_IDX_W   = SEED_BITS + 1;
  localparam int SEED_ENTRIES = 2 ** SEED_IDX_W;

  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 64;

  localparam logic [IDX_W-1:0] REG_CORNER_XY   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CORNER_Z    = 3'd1;
  localparam logic [IDX_W-1:0] REG_COL_STEP_XY = 3'd2;
  localparam logic [IDX_W-1:0] REG_COL_STEP_Z  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW_STEP_XY = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW_STEP_Z  = 3'd5;

  localparam logic [OUT_W-1:0] ONE_Q30          = 32'h4000_0000;
  localparam logic [H_W-1:0]   THREE_HALVES_Q30 = 31'h6000_0000;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    comp_t [2:0] corner;
    comp_t [2:0] col_step;
    comp_t [2:0] row_step;
  } cfg_t;

  typedef struct packed {
    mag_t [2:0] mag;
    logic [2:0] neg;
  } side_t;

  typedef struct packed {
    logic [K_W-1:0] k;
    logic           zero;
    side_t          side;
  } tag_t;

  typedef logic [SEED_ENTRIES-1:0][Y_W-1:0] seed_rom_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x = x_in;
    res = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > x) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != '0) begin
        if (x >= res + bit_v) begin
          x = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Entry index is {parity, mantissa bits below the leading one}.
  function automatic seed_rom_t build_seed_rom();
    seed_rom_t rom;
    logic [63:0] mq;
    logic [63:0] q;
    logic [63:0] jv;
    logic [63:0] par;
    for (int e = 0; e < SEED_ENTRIES; e++) begin
      jv  = 64'(e) & ((64'd1 << SEED_BITS) - 64'd1);
      par = 64'(e) >> SEED_BITS;
      mq  = ((64'd1 << (SEED_BITS + 1)) + (jv << 1) + 64'd1) << par;
      q   = udiv64(64'h8000_0000_0000_0000, mq);
      rom[e] = Y_W'(isqrt64(q << (SEED_BITS - 2)));
    end
    return rom;
  endfunction

  localparam seed_rom_t SEED_ROM = build_seed_rom();

endpackage

FILE: sv/camera_ray_direction_generator.sv
// ----------------------------------------------------------------------------
// camera_ray_direction_generator: pinhole camera primary ray directions
// Forms corner + col * col_step - row * row_step for each pixel and returns
// it scaled to unit length in signed Q1.30.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock and returns one direction beat per
// pixel, in order, through five stages for the vector and its exact squared
// length, four for the leading-one search, normalization and seed lookup,
// three per Newton step and three for scaling. The whole pipeline holds while
// the output beat is stalled. Write the six configuration registers at byte
// address 8 * index while no pixel is in flight. A zero-length direction
// returns zeros with zero_length set; components that would exceed one
// saturate at 2^30.
module camera_ray_direction_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [crdg_pkg::ADDR_W-1:0]       paddr,
  input  logic [crdg_pkg::DATA_W-1:0]       pwdata,
  output logic [crdg_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [crdg_pkg::PIX_W-1:0]        pixel_col,
  input  logic [crdg_pkg::PIX_W-1:0]        pixel_row,
  output logic                              dir_valid,
  input  logic                              dir_stall,
  output logic signed [crdg_pkg::OUT_W-1:0] dir_x,
  output logic signed [crdg_pkg::OUT_W-1:0] dir_y,
  output logic signed [crdg_pkg::OUT_W-1:0] dir_z,
  output logic                              zero_length
);

  crdg_pkg::cfg_t                cfg;
  logic                          en;
  logic                          vec_valid;
  logic [crdg_pkg::LEN_W-1:0]    vec_len;
  crdg_pkg::side_t               vec_side;
  logic                          rs_valid;
  logic [crdg_pkg::Y_W-1:0]      rs_y;
  crdg_pkg::tag_t                rs_tag;

  assign pready      = 1'b1;
  assign en          = !dir_valid || !dir_stall;
  assign pixel_stall = !en;

  crdg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  crdg_vec u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel_valid),
    .col       (pixel_col),
    .row       (pixel_row),
    .cfg       (cfg),
    .out_valid (vec_valid),
    .len       (vec_len),
    .side      (vec_side)
  );

  crdg_rsqrt u_rsqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vec_valid),
    .len       (vec_len),
    .side      (vec_side),
    .out_valid (rs_valid),
    .y         (rs_y),
    .tag       (rs_tag)
  );

  crdg_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (rs_valid),
    .y           (rs_y),
    .tag         (rs_tag),
    .out_valid   (dir_valid),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .zero_length (zero_length)
  );

endmodule

FILE: sv/crdg_cfg.sv
// ----------------------------------------------------------------------------
// crdg_cfg: configuration registers
// Register file for the corner and step vectors behind a simple bus port.
// ----------------------------------------------------------------------------
module crdg_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crdg_pkg::ADDR_W-1:0] paddr,
  input  logic [crdg_pkg::DATA_W-1:0] pwdata,
  output logic [crdg_pkg::DATA_W-1:0] prdata,
  output crdg_pkg::cfg_t              cfg
);

  logic [63:0] corner_xy;
  logic [31:0] corner_z;
  logic [63:0] col_step_xy;
  logic [31:0] col_step_z;
  logic [63:0] row_step_xy;
  logic [31:0] row_step_z;

  logic                       wr;
  logic [crdg_pkg::IDX_W-1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[crdg_pkg::ADDR_W-1:crdg_pkg::ADDR_W-crdg_pkg::IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_xy   <= '0;
      corner_z    <= '0;
      col_step_xy <= '0;
      col_step_z  <= '0;
      row_step_xy <= '0;
      row_step_z  <= '0;
    end else if (wr) begin
      case (idx)
        crdg_pkg::REG_CORNER_XY:   corner_xy   <= pwdata;
        crdg_pkg::REG_CORNER_Z:    corner_z    <= pwdata[31:0];
        crdg_pkg::REG_COL_STEP_XY: col_step_xy <= pwdata;
        crdg_pkg::REG_COL_STEP_Z:  col_step_z  <= pwdata[31:0];
        crdg_pkg::REG_ROW_STEP_XY: row_step_xy <= pwdata;
        crdg_pkg::REG_ROW_STEP_Z:  row_step_z  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      crdg_pkg::REG_CORNER_XY:   prdata = corner_xy;
      crdg_pkg::REG_CORNER_Z:    prdata = {32'd0, corner_z};
      crdg_pkg::REG_COL_STEP_XY: prdata = col_step_xy;
      crdg_pkg::REG_COL_STEP_Z:  prdata = {32'd0, col_step_z};
      crdg_pkg::REG_ROW_STEP_XY: prdata = row_step_xy;
      crdg_pkg::REG_ROW_STEP_Z:  prdata = {32'd0, row_step_z};
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.corner[0]   = corner_xy[63:32];
    cfg.corner[1]   = corner_xy[31:0];
    cfg.corner[2]   = corner_z;
    cfg.col_step[0] = col_step_xy[63:32];
    cfg.col_step[1] = col_step_xy[31:0];
    cfg.col_step[2] = col_step_z;
    cfg.row_step[0] = row_step_xy[63:32];
    cfg.row_step[1] = row_step_xy[31:0];
    cfg.row_step[2] = row_step_z;
  end

endmodule

FILE: sv/crdg_vec.sv
// ----------------------------------------------------------------------------
// crdg_vec: direction vector and squared length
// Five stages: step products, vector sum, split squares, square assembly and
// the exact squared length.
// ----------------------------------------------------------------------------
module crdg_vec (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [crdg_pkg::PIX_W-1:0]  col,
  input  logic [crdg_pkg::PIX_W-1:0]  row,
  input  crdg_pkg::cfg_t              cfg,
  output logic                        out_valid,
  output logic [crdg_pkg::LEN_W-1:0]  len,
  output crdg_pkg::side_t             side
);

  logic [crdg_pkg::PIX_W-1:0] col_sat;
  logic [crdg_pkg::PIX_W-1:0] row_sat;

  logic                              s1_valid;
  logic signed [crdg_pkg::STEP_W-1:0] s1_cp [3];
  logic signed [crdg_pkg::STEP_W-1:0] s1_rp [3];

  logic                            s2_valid;
  logic signed [crdg_pkg::V_W-1:0] s2_v [3];

  logic                                 s3_valid;
  logic [2*crdg_pkg::MAG_HI_W-1:0]      s3_hh [3];
  logic [crdg_pkg::MAG_W-1:0]           s3_hl [3];
  logic [2*crdg_pkg::MAG_LO_W-1:0]      s3_ll [3];
  crdg_pkg::side_t                      s3_side;

  logic                         s4_valid;
  logic [crdg_pkg::LEN_W-1:0]   s4_sq [3];
  crdg_pkg::side_t              s4_side;

  logic                         s5_valid;
  logic [crdg_pkg::LEN_W-1:0]   s5_len;
  crdg_pkg::side_t              s5_side;

  crdg_pkg::mag_t mag [3];

  always_comb begin
    col_sat = col;
    row_sat = row;
    if (int'(col) > crdg_pkg::MAX_WIDTH - 1) col_sat = crdg_pkg::PIX_W'(crdg_pkg::MAX_WIDTH - 1);
    if (int'(row) > crdg_pkg::MAX_HEIGHT - 1) row_sat = crdg_pkg::PIX_W'(crdg_pkg::MAX_HEIGHT - 1);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_v[i][crdg_pkg::V_W-1]) mag[i] = crdg_pkg::MAG_W'(-s2_v[i]);
      else mag[i] = crdg_pkg::MAG_W'(s2_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_cp[i] <= $signed({1'b0, col_sat}) * $signed(cfg.col_step[i]);
        s1_rp[i] <= $signed({1'b0, row_sat}) * $signed(cfg.row_step[i]);
        s2_v[i]  <= crdg_pkg::V_W'($signed(cfg.corner[i])) + crdg_pkg::V_W'(s1_cp[i])
                    - crdg_pkg::V_W'(s1_rp[i]);
        s3_hh[i] <= mag[i][crdg_pkg::MAG_W-1:crdg_pkg::MAG_LO_W]
                    * mag[i][crdg_pkg::MAG_W-1:crdg_pkg::MAG_LO_W];
        s3_hl[i] <= mag[i][crdg_pkg::MAG_W-1:crdg_pkg::MAG_LO_W]
                    * mag[i][crdg_pkg::MAG_LO_W-1:0];
        s3_ll[i] <= mag[i][crdg_pkg::MAG_LO_W-1:0] * mag[i][crdg_pkg::MAG_LO_W-1:0];
        s3_side.mag[i] <= mag[i];
        s3_side.neg[i] <= s2_v[i][crdg_pkg::V_W-1];
        s4_sq[i] <= (crdg_pkg::LEN_W'(s3_hh[i]) << (2 * crdg_pkg::MAG_LO_W))
                    + (crdg_pkg::LEN_W'(s3_hl[i]) << (crdg_pkg::MAG_LO_W + 1))
                    + crdg_pkg::LEN_W'(s3_ll[i]);
      end
      s4_side <= s3_side;
      s5_len  <= s4_sq[0] + s4_sq[1] + s4_sq[2];
      s5_side <= s4_side;
    end
  end

  assign out_valid = s5_valid;
  assign len       = s5_len;
  assign side      = s5_side;

endmodule

FILE: sv/crdg_rsqrt.sv
// ----------------------------------------------------------------------------
// crdg_rsqrt: reciprocal square root of the squared length
// Leading-one search in two stages, mantissa normalization, seed table and
// pipelined Newton steps of three stages each.
// ----------------------------------------------------------------------------
module crdg_rsqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [crdg_pkg::LEN_W-1:0] len,
  input  crdg_pkg::side_t            side,
  output logic                       out_valid,
  output logic [crdg_pkg::Y_W-1:0]   y,
  output crdg_pkg::tag_t             tag
);

  localparam int PAD_W = crdg_pkg::CHUNKS * crdg_pkg::CHUNK_W;

  logic [PAD_W-1:0]              lpad;
  logic [crdg_pkg::CIDX_W-1:0]   cidx;
  logic [crdg_pkg::CHUNK_W-1:0]  chunk;
  logic                          nz;
  logic [crdg_pkg::POS_W-1:0]    pos;
  logic [crdg_pkg::LEN_W+crdg_pkg::FRAC-1:0] lsh;
  logic [crdg_pkg::SEED_BITS-1:0] j;

  logic                          r1_valid;
  logic [crdg_pkg::CIDX_W-1:0]   r1_cidx;
  logic [crdg_pkg::CHUNK_W-1:0]  r1_chunk;
  logic                          r1_zero;
  logic [crdg_pkg::LEN_W-1:0]    r1_len;
  crdg_pkg::side_t               r1_side;

  logic                          r2_valid;
  logic [crdg_pkg::K_W-1:0]      r2_k;
  logic                          r2_par;
  logic                          r2_zero;
  logic [crdg_pkg::LEN_W-1:0]    r2_len;
  crdg_pkg::side_t               r2_side;

  logic                          r3_valid;
  logic [crdg_pkg::M_W-1:0]      r3_m;
  logic                          r3_par;
  crdg_pkg::tag_t                r3_tag;

  logic                          nv   [crdg_pkg::NEWTON_STEPS+1];
  logic [crdg_pkg::Y_W-1:0]      ny   [crdg_pkg::NEWTON_STEPS+1];
  logic [crdg_pkg::M_W-1:0]      nm   [crdg_pkg::NEWTON_STEPS+1];
  crdg_pkg::tag_t                ntag [crdg_pkg::NEWTON_STEPS+1];

  always_comb begin
    lpad  = PAD_W'(len);
    cidx  = '0;
    chunk = lpad[crdg_pkg::CHUNK_W-1:0];
    nz    = 1'b0;
    for (int c = 0; c < crdg_pkg::CHUNKS; c++) begin
      if (lpad[c*crdg_pkg::CHUNK_W +: crdg_pkg::CHUNK_W] != '0) begin
        cidx  = crdg_pkg::CIDX_W'(c);
        chunk = lpad[c*crdg_pkg::CHUNK_W +: crdg_pkg::CHUNK_W];
        nz    = 1'b1;
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int b = 0; b < crdg_pkg::CHUNK_W; b++) begin
      if (r1_chunk[b]) pos = crdg_pkg::POS_W'(b);
    end
  end

  assign lsh = {r2_len, {crdg_pkg::FRAC{1'b0}}} >> {r2_k, 1'b0};

  always_comb begin
    if (r3_par) j = r3_m[crdg_pkg::FRAC+1-crdg_pkg::SEED_BITS +: crdg_pkg::SEED_BITS];
    else j = r3_m[crdg_pkg::FRAC-crdg_pkg::SEED_BITS +: crdg_pkg::SEED_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      r3_valid <= 1'b0;
      nv[0]    <= 1'b0;
    end else if (en) begin
      r1_valid <= in_valid;
      r2_valid <= r1_valid;
      r3_valid <= r2_valid;
      nv[0]    <= r3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_cidx  <= cidx;
      r1_chunk <= chunk;
      r1_zero  <= !nz;
      r1_len   <= len;
      r1_side  <= side;

      r2_k     <= {r1_cidx, pos[crdg_pkg::POS_W-1:1]};
      r2_par   <= pos[0];
      r2_zero  <= r1_zero;
      r2_len   <= r1_len;
      r2_side  <= r1_side;

      r3_m         <= lsh[crdg_pkg::M_W-1:0];
      r3_par       <= r2_par;
      r3_tag.k     <= r2_k;
      r3_tag.zero  <= r2_zero;
      r3_tag.side  <= r2_side;

      ny[0]   <= crdg_pkg::SEED_ROM[{r3_par, j}];
      nm[0]   <= r3_m;
      ntag[0] <= r3_tag;
    end
  end

  for (genvar s = 0; s < crdg_pkg::NEWTON_STEPS; s++) begin : g_newton
    logic                             va;
    logic                             vb;
    logic [crdg_pkg::T_W-1:0]         ta;
    logic [crdg_pkg::Y_W-1:0]         ya;
    logic [crdg_pkg::Y_W-1:0]         yb;
    logic [crdg_pkg::M_W-1:0]         ma;
    logic [crdg_pkg::M_W-1:0]         mb;
    logic [crdg_pkg::U_W-1:0]         ub;
    crdg_pkg::tag_t                   taga;
    crdg_pkg::tag_t                   tagb;
    logic [2*crdg_pkg::Y_W-1:0]       yy;
    logic [63:0]                      mt;
    logic [crdg_pkg::H_W-1:0]         h;
    logic [crdg_pkg::Y_W+crdg_pkg::H_W-1:0] yh;

    assign yy = ny[s] * ny[s];
    assign mt = 64'(ma) * 64'(ta);
    assign h  = (ub > crdg_pkg::U_W'(crdg_pkg::THREE_HALVES_Q30)) ? '0
                : crdg_pkg::THREE_HALVES_Q30 - ub[crdg_pkg::H_W-1:0];
    assign yh = yb * h;

    always_ff @(posedge clk) begin
      if (rst) begin
        va      <= 1'b0;
        vb      <= 1'b0;
        nv[s+1] <= 1'b0;
      end else if (en) begin
        va      <= nv[s];
        vb      <= va;
        nv[s+1] <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ta        <= yy[crdg_pkg::FRAC +: crdg_pkg::T_W];
        ya        <= ny[s];
        ma        <= nm[s];
        taga      <= ntag[s];
        ub        <= mt[crdg_pkg::FRAC+1 +: crdg_pkg::U_W];
        yb        <= ya;
        mb        <= ma;
        tagb      <= taga;
        ny[s+1]   <= yh[crdg_pkg::FRAC +: crdg_pkg::Y_W];
        nm[s+1]   <= mb;
        ntag[s+1] <= tagb;
      end
    end
  end

  assign out_valid = nv[crdg_pkg::NEWTON_STEPS];
  assign y         = ny[crdg_pkg::NEWTON_STEPS];
  assign tag       = ntag[crdg_pkg::NEWTON_STEPS];

endmodule

FILE: sv/crdg_scale.sv
// ----------------------------------------------------------------------------
// crdg_scale: output scaling
// Multiplies each magnitude by the reciprocal root in two halves, assembles
// the product, then shifts, saturates and restores the sign.
// ----------------------------------------------------------------------------
module crdg_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [crdg_pkg::Y_W-1:0]          y,
  input  crdg_pkg::tag_t                    tag,
  output logic                              out_valid,
  output logic signed [crdg_pkg::OUT_W-1:0] dir_x,
  output logic signed [crdg_pkg::OUT_W-1:0] dir_y,
  output logic signed [crdg_pkg::OUT_W-1:0] dir_z,
  output logic                              zero_length
);

  logic                                          o1_valid;
  logic [crdg_pkg::MAG_LO_W+crdg_pkg::Y_W-1:0]   o1_plo [3];
  logic [crdg_pkg::MAG_HI_W+crdg_pkg::Y_W-1:0]   o1_phi [3];
  crdg_pkg::tag_t                                o1_tag;

  logic                          o2_valid;
  logic [crdg_pkg::PROD_W-1:0]   o2_prod [3];
  crdg_pkg::tag_t                o2_tag;

  logic [crdg_pkg::PROD_W-1:0]   shifted;
  logic [crdg_pkg::OUT_W-1:0]    mag_sat;
  logic [crdg_pkg::OUT_W-1:0]    res [3];

  always_comb begin
    shifted = '0;
    mag_sat = '0;
    for (int i = 0; i < 3; i++) begin
      shifted = o2_prod[i] >> o2_tag.k;
      if (shifted > crdg_pkg::PROD_W'(crdg_pkg::ONE_Q30)) mag_sat = crdg_pkg::ONE_Q30;
      else mag_sat = shifted[crdg_pkg::OUT_W-1:0];
      if (o2_tag.zero) res[i] = '0;
      else if (o2_tag.side.neg[i]) res[i] = -mag_sat;
      else res[i] = mag_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid  <= 1'b0;
      o2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      o1_valid  <= in_valid;
      o2_valid  <= o1_valid;
      out_valid <= o2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_plo[i]  <= tag.side.mag[i][crdg_pkg::MAG_LO_W-1:0] * y;
        o1_phi[i]  <= tag.side.mag[i][crdg_pkg::MAG_W-1:crdg_pkg::MAG_LO_W] * y;
        o2_prod[i] <= (crdg_pkg::PROD_W'(o1_phi[i]) << crdg_pkg::MAG_LO_W)
                      + crdg_pkg::PROD_W'(o1_plo[i]);
      end
      o1_tag      <= tag;
      o2_tag      <= o1_tag;
      dir_x       <= res[0];
      dir_y       <= res[1];
      dir_z       <= res[2];
      zero_length <= o2_tag.zero;
    end
  end

endmodule

FILE: bench/camera_ray_direction_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_ray_direction_generator_tb: self-checking bench for the ray generator
// Programs the camera registers over the APB port, streams pixel beats with
// random gaps and output stalls, and compares every direction beat against a
// bit-exact predictor of the normalization datapath.
// ----------------------------------------------------------------------------
module camera_ray_direction_generator_tb;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zl;
  } dir_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [crdg_pkg::ADDR_W-1:0] paddr = '0;
  logic [crdg_pkg::DATA_W-1:0] pwdata = '0;
  logic [crdg_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic [crdg_pkg::PIX_W-1:0] pixel_col = '0, pixel_row = '0;
  logic dir_valid;
  logic dir_stall = 1'b0;
  logic signed [crdg_pkg::OUT_W-1:0] dir_x, dir_y, dir_z;
  logic zero_length;

  dir_t expected_dirs[$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int long_hold_req = 0;
  int long_hold_seen = 0;
  bit gaps_on = 1'b1;
  logic [63:0] cam_reg[6];

  camera_ray_direction_generator i_dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("camera_ray_direction_generator: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt_u64(logic [63:0] a);
    logic [63:0] x, res, b;
    x = a;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] rsqrt_seed(int par, logic [63:0] j);
    logic [63:0] mq;
    mq = ((64'd1 << (crdg_pkg::SEED_BITS + 1)) + 2 * j + 1) << par;
    return isqrt_u64((64'h8000_0000_0000_0000 / mq) << (crdg_pkg::SEED_BITS - 2));
  endfunction

  function automatic logic [31:0] scale_comp(logic signed [63:0] v, logic [63:0] y, int k);
    logic [127:0] prod;
    logic [63:0] mag, m;
    mag = v < 0 ? -v : v;
    prod = ({64'd0, mag} * {64'd0, y}) >> k;
    m = (prod > 128'h4000_0000) ? 64'h4000_0000 : prod[63:0];
    if (v < 0) m = -m;
    return m[31:0];
  endfunction

  function automatic dir_t ray_direction(logic [11:0] col, logic [11:0] row);
    logic signed [63:0] v[3];
    logic [127:0] len;
    logic [63:0] a, m, y, j, t, u, h;
    int p, k, par;
    dir_t d;
    for (int i = 0; i < 3; i++) begin
      logic signed [31:0] c, cs, rs;
      c  = (i == 0) ? cam_reg[0][63:32] : (i == 1) ? cam_reg[0][31:0] : cam_reg[1][31:0];
      cs = (i == 0) ? cam_reg[2][63:32] : (i == 1) ? cam_reg[2][31:0] : cam_reg[3][31:0];
      rs = (i == 0) ? cam_reg[4][63:32] : (i == 1) ? cam_reg[4][31:0] : cam_reg[5][31:0];
      v[i] = 64'(c) + $signed({52'd0, col}) * 64'(cs) - $signed({52'd0, row}) * 64'(rs);
    end
    len = 0;
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      len = len + {64'd0, a} * {64'd0, a};
    end
    d = '0;
    if (len == 0) begin
      d.zl = 1'b1;
      return d;
    end
    p = 0;
    for (int i = 0; i < 128; i++) if (len[i]) p = i;
    k = p >> 1;
    par = p & 1;
    if (2 * k >= 30) m = 64'(len >> (2 * k - 30)) & 64'hFFFF_FFFF;
    else m = (len[63:0] << (30 - 2 * k)) & 64'hFFFF_FFFF;
    j = (m >> (30 + par - crdg_pkg::SEED_BITS)) & ((64'd1 << crdg_pkg::SEED_BITS) - 1);
    y = rsqrt_seed(par, j);
    for (int i = 0; i < crdg_pkg::NEWTON_STEPS; i++) begin
      t = (y * y) >> 30;
      u = (m * t) >> 31;
      h = (u > 64'h6000_0000) ? 0 : 64'h6000_0000 - u;
      y = (y * h) >> 30;
    end
    d.x = scale_comp(v[0], y, k);
    d.y = scale_comp(v[1], y, k);
    d.z = scale_comp(v[2], y, k);
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    dir_t want;
    if (!rst && dir_valid && !dir_stall) begin
      if (expected_dirs.size() == 0) begin
        report_mismatch("unexpected beat", dir_x, 32'd0);
      end else begin
        want = expected_dirs.pop_front();
        if (dir_x !== want.x) report_mismatch("dir_x", dir_x, want.x);
        if (dir_y !== want.y) report_mismatch("dir_y", dir_y, want.y);
        if (dir_z !== want.z) report_mismatch("dir_z", dir_z, want.z);
        if (zero_length !== want.zl) begin
          report_mismatch("zero_length", {31'd0, zero_length}, {31'd0, want.zl});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (long_hold_req != long_hold_seen) begin
      long_hold_seen <= long_hold_req;
      hold_cycles <= 199;
      dir_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      dir_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      hold_cycles <= $urandom_range(0, 3);
      dir_stall <= 1'b1;
    end else begin
      dir_stall <= 1'b0;
    end
  end

  task automatic write_reg(int idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= crdg_pkg::ADDR_W'(8 * idx); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cam_reg[idx] = (idx % 2 == 1) ? {32'd0, value[31:0]} : value;
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    do @(posedge clk); while (pixel_stall);
    expected_dirs.push_back(ray_direction(col, row));
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_camera(logic [63:0] c0, c1, c2, c3, c4, c5);
    drain();
    write_reg(crdg_pkg::REG_CORNER_XY, c0);
    write_reg(crdg_pkg::REG_CORNER_Z, c1);
    write_reg(crdg_pkg::REG_COL_STEP_XY, c2);
    write_reg(crdg_pkg::REG_COL_STEP_Z, c3);
    write_reg(crdg_pkg::REG_ROW_STEP_XY, c4);
    write_reg(crdg_pkg::REG_ROW_STEP_Z, c5);
  endtask

  task automatic test_zero_direction();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
  endtask

  task automatic test_typical_camera();
    load_camera({32'hF000_0000, 32'h1000_0000}, 64'h1000_0000,
                {32'h0002_0000, 32'h0}, 64'h0, {32'h0, 32'h0002_0000}, 64'h0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'h800, 12'h800);
  endtask

  task automatic test_extremes();
    load_camera({32'h8000_0000, 32'h7FFF_FFFF}, 64'h8000_0000,
                {32'h7FFF_FFFF, 32'h8000_0000}, 64'h7FFF_FFFF,
                {32'h8000_0000, 32'h7FFF_FFFF}, 64'hFFFF_FFFF_8000_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    load_camera(64'h0000_0001_0000_0000, 64'h0, 64'h0, 64'h1, 64'h1, 64'h0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd1, 12'd1);
  endtask

  task automatic test_random_cameras();
    for (int s = 0; s < 10; s++) begin
      load_camera({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom} >> $urandom_range(0, 20),
                  $urandom >> $urandom_range(0, 20),
                  {$urandom, $urandom} >> $urandom_range(0, 20),
                  $urandom >> $urandom_range(0, 20));
      for (int i = 0; i < 90; i++) begin
        if (s == 3 && i == 10) long_hold_req++;
        send_pixel(12'($urandom), 12'($urandom));
      end
    end
  endtask

  task automatic test_no_gaps();
    drain();
    gaps_on = 1'b0;
    for (int i = 0; i < 100; i++) send_pixel(12'($urandom), 12'($urandom));
  endtask

  initial begin
    cam_reg = '{default: 64'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_zero_direction();
    test_typical_camera();
    test_extremes();
    test_random_cameras();
    test_no_gaps();
    drain();
    if (errors == 0) begin
      $display("camera_ray_direction_generator: match");
    end else begin
      $display("camera_ray_direction_generator: mismatch");
    end
    $finish;
  end
endmodule
